@@ rtl/wofu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the odometry fusion unit.
`timescale 1ns / 1ps
package wofu_pkg;

  // Step index, five bits wide: enough for the longest phase while CORDIC_STEPS is at most 32.
  localparam int unsigned IDX_W = 5;
  localparam int unsigned PROD_W = 67;
  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned MUL_LAST = 4;
  localparam int unsigned GAIN_LAST = 6;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic [10:0] DIV_CONST = 11'd1000;
  // divide by 1000 in 16-bit digits: four digits cover any quotient
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DIV_LAST = 3;
  // ceil(2^36 / 1000), exact for every partial remainder below 1000 * 2^16
  localparam logic [26:0] RECIP_1000 = 27'd68719477;
  localparam int unsigned RECIP_SHIFT = 36;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_SYNC   = 2'd1;
  localparam logic [1:0] REG_VGAIN  = 2'd2;
  localparam logic [1:0] REG_PGAIN  = 2'd3;

  typedef struct packed {
    logic             load;
    logic             decide;
    logic             cordic;
    logic             mul;
    logic             div;
    logic             adv;
    logic             gain;
    logic             commit;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } wofu_cmd_t;

  typedef struct packed {
    logic process;
    logic out_free;
  } wofu_sts_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667330;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // p / 2^16, rounded half away from zero
  function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q = (mag + PROD_W'(32768)) >> 16;
    return p[PROD_W-1] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(PROD_W'(64'sh7fffffff))) r = 32'sh7fffffff;
    else if (v < -$signed(PROD_W'(64'sh80000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [23:0] r;
    if (v > $signed(PROD_W'(64'sh7fffff))) r = 24'sh7fffff;
    else if (v < -$signed(PROD_W'(64'sh800000))) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

@@ rtl/wofu_ctrl.sv @@
// Sequencer for the odometry fusion unit: steps the datapath through its phases.
`timescale 1ns / 1ps
module wofu_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wofu_pkg::wofu_sts_t sts_i,
  output wofu_pkg::wofu_cmd_t cmd_o
);
  import wofu_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECIDE = 9'b000000010,
    ST_CORDIC = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_ADV    = 9'b000100000,
    ST_GAIN   = 9'b001000000,
    ST_COMMIT = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        idx_d = '0;
        state_d = sts_i.process ? ST_CORDIC : ST_OUT;
      end
      ST_CORDIC: begin
        cmd_o.cordic = 1'b1;
        if (idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
          idx_d = '0;
          state_d = ST_MUL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (idx_q == IDX_W'(MUL_LAST)) begin
          idx_d = '0;
          state_d = ST_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (idx_q == IDX_W'(DIV_LAST)) begin
          idx_d = '0;
          state_d = ST_ADV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        idx_d = '0;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        if (idx_q == IDX_W'(GAIN_LAST)) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ rtl/wofu_datapath.sv @@
// Datapath of the odometry fusion unit: state, CORDIC, shared multiplier, divide lanes.
`timescale 1ns / 1ps
module wofu_datapath #(
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wofu_pkg::wofu_cmd_t cmd_i,
  output wofu_pkg::wofu_sts_t sts_o,
  input  logic [215:0]        in_data_i,
  input  logic                in_clear_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [16:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [199:0]        out_data_o,
  output logic                out_user_o
);
  import wofu_pkg::*;

  localparam int unsigned K  = 30 - FRAC_BITS;
  localparam logic [62:0] HALF_DEN = 63'(500) << K;
  localparam int unsigned LANES = 4;

  // captured transaction
  logic [31:0]        ft_q;
  logic signed [15:0] spd_in_q;
  logic [31:0]        dist_q;
  logic               onl_q, stat_q, clr_q;
  logic signed [31:0] ipx_q, ipy_q;
  logic signed [23:0] ivx_q, ivy_q;
  logic signed [15:0] head_q;

  // odometry state
  logic signed [31:0] odo_x_q, odo_y_q;
  logic [31:0]        prev_dist_q, prev_time_q;
  logic signed [15:0] held_q;
  logic               init_q, active_q;

  // configuration
  logic        en_q;
  logic [16:0] sync_q, vg_q, pg_q;

  // CORDIC
  logic signed [CORDIC_W-1:0] cx_q, cy_q, cz_q;
  logic                       flip_q;

  logic signed [PROD_W-1:0] prod_q;

  // divide-by-1000 lanes: dd*c, dd*s, spd*c, spd*s
  logic [DIV_W-1:0] lt_q  [LANES];
  logic [9:0]       rem_q [LANES];
  logic             ln_q  [LANES];

  logic signed [31:0] px_q, py_q, qvx_q, qvy_q;
  logic signed [23:0] vcx_q, vcy_q;
  logic signed [31:0] pcx_q, pcy_q;
  logic               valid_q;

  logic [199:0] m_data_q;
  logic         m_user_q, m_valid_q;

  logic go;
  logic signed [CORDIC_W-1:0] z0, z0_adj, cc, ss, sh_x, sh_y, at;
  logic z0_flip;
  logic signed [32:0] dd33, spd33, mul_a;
  logic signed [33:0] mul_b;
  logic signed [PROD_W-1:0] r16;
  logic [PROD_W-1:0] pmag;
  logic [62:0] t_sum;
  logic [DIV_W-1:0] t_load;
  logic signed [DIV_W:0] qs [LANES];
  logic [25:0] dv_num  [LANES];
  logic [52:0] dv_prod [LANES];
  logic [15:0] dv_quo  [LANES];
  logic [9:0]  dv_rem  [LANES];
  logic [IDX_W-1:0] gidx;

  assign go = en_q & onl_q & ~stat_q;

  always_comb begin
    sts_o.process  = ~clr_q & (ft_q != prev_time_q) & go & init_q;
    sts_o.out_free = ~m_valid_q | out_ready_i;
  end

  // heading to CORDIC angle, folded into the right half plane
  always_comb begin
    z0 = {{2{head_q[15]}}, head_q, 16'b0};
    z0_adj = z0;
    z0_flip = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0_adj = z0 - 34'sd2147483648;
      z0_flip = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0_adj = z0 + 34'sd2147483648;
      z0_flip = 1'b1;
    end
  end

  assign sh_x = cx_q >>> cmd_i.idx;
  assign sh_y = cy_q >>> cmd_i.idx;
  assign at   = atan_turn(cmd_i.idx[4:0]);
  assign cc   = flip_q ? -cx_q : cx_q;
  assign ss   = flip_q ? -cy_q : cy_q;

  assign dd33  = 33'($signed(dist_q - prev_dist_q));
  assign spd33 = 33'(held_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul) begin
      case (cmd_i.idx)
        IDX_W'(0): begin mul_a = dd33;  mul_b = cc; end
        IDX_W'(1): begin mul_a = dd33;  mul_b = ss; end
        IDX_W'(2): begin mul_a = spd33; mul_b = cc; end
        IDX_W'(3): begin mul_a = spd33; mul_b = ss; end
        default: ;
      endcase
    end else if (cmd_i.gain) begin
      case (cmd_i.idx)
        IDX_W'(0): begin
          mul_a = $signed({16'b0, sync_q}); mul_b = 34'(ipx_q) - 34'(px_q);
        end
        IDX_W'(1): begin
          mul_a = $signed({16'b0, sync_q}); mul_b = 34'(ipy_q) - 34'(py_q);
        end
        IDX_W'(2): begin
          mul_a = $signed({16'b0, vg_q}); mul_b = 34'(qvx_q) - 34'(ivx_q);
        end
        IDX_W'(3): begin
          mul_a = $signed({16'b0, vg_q}); mul_b = 34'(qvy_q) - 34'(ivy_q);
        end
        IDX_W'(4): begin
          mul_a = $signed({16'b0, pg_q}); mul_b = 34'(px_q) - 34'(ipx_q);
        end
        IDX_W'(5): begin
          mul_a = $signed({16'b0, pg_q}); mul_b = 34'(py_q) - 34'(ipy_q);
        end
        default: ;
      endcase
    end
  end

  assign r16    = rnd16(prod_q);
  assign pmag   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign t_sum  = pmag[62:0] + HALF_DEN;
  assign t_load = DIV_W'(t_sum >> K);
  assign gidx   = cmd_i.idx - 1'b1;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qs[l] = ln_q[l] ? -$signed({1'b0, lt_q[l]}) : $signed({1'b0, lt_q[l]});
    end
  end

  // one 16-bit quotient digit per cycle and lane, by reciprocal multiply
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dv_num[l]  = {rem_q[l], lt_q[l][DIV_W-1 -: 16]};
      dv_prod[l] = 53'(dv_num[l]) * 53'(RECIP_1000);
      dv_quo[l]  = 16'(dv_prod[l] >> RECIP_SHIFT);
      dv_rem[l]  = 10'(dv_num[l] - 26'(dv_quo[l]) * 26'(DIV_CONST));
    end
  end

  // control-bearing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odo_x_q     <= '0;
      odo_y_q     <= '0;
      prev_dist_q <= '0;
      prev_time_q <= '0;
      held_q      <= '0;
      init_q      <= 1'b0;
      active_q    <= 1'b0;
      en_q        <= 1'b1;
      sync_q      <= 17'd655;
      vg_q        <= 17'd3277;
      pg_q        <= 17'd3277;
      valid_q     <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENABLE: begin
            en_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) active_q <= 1'b0;
          end
          REG_SYNC:  sync_q <= cfg_data_i;
          REG_VGAIN: vg_q   <= cfg_data_i;
          REG_PGAIN: pg_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decide) begin
        valid_q <= 1'b0;
        if (clr_q) begin
          odo_x_q     <= '0;
          odo_y_q     <= '0;
          prev_dist_q <= '0;
          prev_time_q <= '0;
          held_q      <= '0;
          init_q      <= 1'b0;
          active_q    <= 1'b0;
        end else if (ft_q != prev_time_q) begin
          prev_time_q <= ft_q;
          held_q      <= spd_in_q;
          if (!go) begin
            active_q <= 1'b0;
          end else if (!init_q) begin
            odo_x_q     <= ipx_q;
            odo_y_q     <= ipy_q;
            prev_dist_q <= dist_q;
            init_q      <= 1'b1;
            active_q    <= 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        odo_x_q     <= px_q;
        odo_y_q     <= py_q;
        prev_dist_q <= dist_q;
        active_q    <= 1'b1;
        valid_q     <= 1'b1;
      end
      if (cmd_i.out_load) m_valid_q <= 1'b1;
      else if (out_ready_i) m_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ft_q     <= in_data_i[31:0];
      spd_in_q <= in_data_i[47:32];
      dist_q   <= in_data_i[79:48];
      onl_q    <= in_data_i[80];
      stat_q   <= in_data_i[81];
      ipx_q    <= in_data_i[113:82];
      ipy_q    <= in_data_i[145:114];
      ivx_q    <= in_data_i[169:146];
      ivy_q    <= in_data_i[193:170];
      head_q   <= in_data_i[209:194];
      clr_q    <= in_clear_i;
    end
    if (cmd_i.decide) begin
      vcx_q  <= '0;
      vcy_q  <= '0;
      pcx_q  <= '0;
      pcy_q  <= '0;
      cx_q   <= CORDIC_K_Q30;
      cy_q   <= '0;
      cz_q   <= z0_adj;
      flip_q <= z0_flip;
    end
    if (cmd_i.cordic) begin
      if (!cz_q[CORDIC_W-1]) begin
        cx_q <= cx_q - sh_y;
        cy_q <= cy_q + sh_x;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + sh_y;
        cy_q <= cy_q - sh_x;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul || cmd_i.gain) prod_q <= mul_a * mul_b;
    if (cmd_i.mul && cmd_i.idx != '0) begin
      lt_q[gidx[1:0]]  <= t_load;
      ln_q[gidx[1:0]]  <= prod_q[PROD_W-1];
      rem_q[gidx[1:0]] <= '0;
    end
    // long division by 1000, most significant digit first
    if (cmd_i.div) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= dv_rem[l];
        lt_q[l]  <= {lt_q[l][DIV_W-17:0], dv_quo[l]};
      end
    end
    if (cmd_i.adv) begin
      px_q  <= sat32(PROD_W'(odo_x_q) + PROD_W'(qs[0]));
      py_q  <= sat32(PROD_W'(odo_y_q) + PROD_W'(qs[1]));
      qvx_q <= qs[2][31:0];
      qvy_q <= qs[3][31:0];
    end
    if (cmd_i.gain && cmd_i.idx != '0) begin
      case (gidx)
        IDX_W'(0): px_q  <= sat32(PROD_W'(px_q) + r16);
        IDX_W'(1): py_q  <= sat32(PROD_W'(py_q) + r16);
        IDX_W'(2): vcx_q <= sat24(r16);
        IDX_W'(3): vcy_q <= sat24(r16);
        IDX_W'(4): pcx_q <= sat32(r16);
        IDX_W'(5): pcy_q <= sat32(r16);
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      m_user_q <= valid_q;
      m_data_q <= {7'b0, active_q, held_q, odo_y_q, odo_x_q,
                   pcy_q, pcx_q, vcy_q, vcx_q};
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_data_q;
  assign out_user_o  = m_user_q;

endmodule

@@ rtl/wheel_odometry_ins_fusion_unit.sv @@
// A fused frame steps through the CORDIC, multiply, divide, advance, gain and commit
//   phases; unfused frames, repeated frames and clears go from the decide step straight
//   to the output step, where the result waits until the output register is free. One frame is
//   processed at a time; the iterative CORDIC, the shared multiplier steps and the
//   four-digit divide-by-1000 lanes set how long a fused frame takes.
// Reset: asynchronous, active low; clears odometry state, loads register defaults.
`timescale 1ns / 1ps
module wheel_odometry_ins_fusion_unit #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_time_ms, wheel_speed_mm_s, wheel_distance_mm, encoder_online,
  // platform_stationary, inertial_pos_x, inertial_pos_y, inertial_vel_x,
  // inertial_vel_y, heading_angle, zero fill
  input  logic [215:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // clear_request
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vel_correction_x, vel_correction_y, pos_correction_x, pos_correction_y,
  // odometry_x, odometry_y, latched_speed_mm_s, fusion_active, zero fill
  output logic [199:0] m_axis_tdata,
  output logic         m_axis_tuser,  // correction_valid
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);
  import wofu_pkg::*;

  wofu_cmd_t cmd;
  wofu_sts_t sts;

  wofu_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  wofu_datapath #(
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_clear_i (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule
